FILE: rtl/iir4_pkg.sv
// shared types and constants for the fourth-order direct form I filter
// no dependencies; imported by iir_order4_direct_form1_unit
package iir4_pkg;

  localparam int unsigned DEF_ORDER = 4;
  localparam int unsigned MAX_ORDER = 4;

  localparam int unsigned RAW_W    = 12;
  localparam int unsigned X_W      = 8;
  localparam int unsigned Y_W      = 32;
  localparam int unsigned TAP_W    = 32;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ACC_W    = 52;
  localparam int unsigned PROD_W   = 64;
  localparam int unsigned DEN_SHIFT = 16;
  localparam int unsigned OUT_SHIFT = 12;
  localparam int unsigned HIST_DEPTH = 4;
  localparam int unsigned HIST_AW  = 2;
  localparam int unsigned ENTRY_W  = X_W + Y_W;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_4  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_12 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_34 = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAP0,
    S_NUM,
    S_DEN,
    S_DRAIN,
    S_WB
  } state_e;

  typedef enum logic [1:0] {
    MUL_B0,
    MUL_NUM,
    MUL_DEN
  } mul_sel_e;

endpackage

FILE: rtl/iir_order4_direct_form1_unit.sv
// fourth-order direct form I iir filter with a shared multiply-accumulate
// the sample and output history live in one small synchronous memory
// depends on iir4_pkg
//
// channel   dir  handshake               payload
// input     in   in_valid_i / in_stall_o  raw_sample_i
// result    out  out_valid_o / out_stall_i dac_code_o, clipped_o
// config    in   cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// one item is taken at a time: the next is accepted only after the single
// multiplier has walked the taps, with one history memory read per past
// sample, and the result has been written back.
// reset clears the taps, the write position and the history valid bits.
// a full result register holds the write-back, so a stalled output blocks
// the item after the one waiting to be taken.
module iir_order4_direct_form1_unit
  import iir4_pkg::*;
#(
  parameter int unsigned ORDER = DEF_ORDER
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [RAW_W-1:0]     raw_sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [X_W-1:0]       dac_code_o,
  output logic                 clipped_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam logic [2:0] LAST_K = 3'(ORDER);

  // configuration
  logic [CFG_W-1:0] num01_q, num23_q, den12_q, den34_q;
  logic [TAP_W-1:0] num4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num01_q <= '0;
      num23_q <= '0;
      num4_q  <= '0;
      den12_q <= '0;
      den34_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUM_01: num01_q <= cfg_wdata_i;
        REG_NUM_23: num23_q <= cfg_wdata_i;
        REG_NUM_4:  num4_q  <= cfg_wdata_i[TAP_W-1:0];
        REG_DEN_12: den12_q <= cfg_wdata_i;
        REG_DEN_34: den34_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control state
  state_e           state_q, state_d;
  logic [2:0]       k_q, k_d;
  logic [HIST_AW-1:0] pos_q;
  logic             out_valid_q;

  logic             rd_en, wr_en, acc_clr, acc_add, mul_en;
  logic [2:0]       rd_k;
  mul_sel_e         mul_sel;
  logic             out_free;

  assign out_free = !(out_valid_q && out_stall_i);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_TAP0;
        end
      end
      S_TAP0: begin
        k_d     = 3'd1;
        state_d = S_NUM;
      end
      S_NUM: state_d = S_DEN;
      S_DEN: begin
        if (k_q == LAST_K) begin
          state_d = S_DRAIN;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_NUM;
        end
      end
      S_DRAIN: state_d = S_WB;
      S_WB: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    rd_k       = k_q + 3'd1;
    wr_en      = 1'b0;
    acc_clr    = 1'b0;
    acc_add    = 1'b0;
    mul_en     = 1'b0;
    mul_sel    = MUL_B0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        acc_clr    = 1'b1;
      end
      S_TAP0: begin
        mul_en = 1'b1;
        rd_en  = 1'b1;
        rd_k   = 3'd1;
      end
      S_NUM: begin
        acc_add = 1'b1;
        mul_en  = 1'b1;
        mul_sel = MUL_NUM;
      end
      S_DEN: begin
        acc_add = 1'b1;
        mul_en  = 1'b1;
        mul_sel = MUL_DEN;
        rd_en   = (k_q != LAST_K);
      end
      S_DRAIN: acc_add = 1'b1;
      S_WB:    wr_en   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= 3'd1;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (wr_en) begin
        pos_q <= pos_q + HIST_AW'(1);
      end
    end
  end

  // history memory: {x, y} per slot, valid bits stand in for the zero reset
  logic [ENTRY_W-1:0]    hist_mem [HIST_DEPTH];
  logic [ENTRY_W-1:0]    rd_data_q;
  logic [HIST_DEPTH-1:0] hist_vld_q;
  logic                  rd_vld_q;
  logic [HIST_AW-1:0]    rd_addr;
  logic [Y_W-1:0]        y_new;
  logic [X_W-1:0]        x_q;

  assign rd_addr = pos_q - rd_k[HIST_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= hist_mem[rd_addr];
    end
    if (wr_en) begin
      hist_mem[pos_q] <= {x_q, y_new};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_q <= hist_vld_q[rd_addr];
      end
      if (wr_en) begin
        hist_vld_q[pos_q] <= 1'b1;
      end
    end
  end

  // shared multiplier
  logic [X_W-1:0]           x_hist;
  logic [Y_W-1:0]           y_hist;
  logic signed [TAP_W-1:0]  mul_a;
  logic signed [Y_W:0]      mul_b;
  logic signed [TAP_W+Y_W:0] mul_p;
  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_den_q;

  assign x_hist = rd_vld_q ? rd_data_q[ENTRY_W-1 -: X_W] : '0;
  assign y_hist = rd_vld_q ? rd_data_q[Y_W-1:0] : '0;

  function automatic logic [TAP_W-1:0] num_tap(input logic [2:0] k,
                                               input logic [CFG_W-1:0] n01,
                                               input logic [CFG_W-1:0] n23,
                                               input logic [TAP_W-1:0] n4);
    logic [TAP_W-1:0] t;
    case (k)
      3'd1:    t = n01[CFG_W-1:TAP_W];
      3'd2:    t = n23[TAP_W-1:0];
      3'd3:    t = n23[CFG_W-1:TAP_W];
      default: t = n4;
    endcase
    return t;
  endfunction

  function automatic logic [TAP_W-1:0] den_tap(input logic [2:0] k,
                                               input logic [CFG_W-1:0] d12,
                                               input logic [CFG_W-1:0] d34);
    logic [TAP_W-1:0] t;
    case (k)
      3'd1:    t = d12[TAP_W-1:0];
      3'd2:    t = d12[CFG_W-1:TAP_W];
      3'd3:    t = d34[TAP_W-1:0];
      default: t = d34[CFG_W-1:TAP_W];
    endcase
    return t;
  endfunction

  always_comb begin
    case (mul_sel)
      MUL_NUM: begin
        mul_a = $signed(num_tap(k_q, num01_q, num23_q, num4_q));
        mul_b = $signed({{(Y_W-X_W+1){1'b0}}, x_hist});
      end
      MUL_DEN: begin
        mul_a = $signed(den_tap(k_q, den12_q, den34_q));
        mul_b = $signed({y_hist[Y_W-1], y_hist});
      end
      default: begin
        mul_a = $signed(num01_q[TAP_W-1:0]);
        mul_b = $signed({{(Y_W-X_W+1){1'b0}}, x_q});
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      x_q <= raw_sample_i[RAW_W-1 -: X_W];
    end
    if (mul_en) begin
      prod_q     <= $signed(mul_p[PROD_W-1:0]);
      prod_den_q <= (mul_sel == MUL_DEN);
    end
  end

  // accumulator in Q.28; past-output products are floored to Q.28 first
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] term;

  always_comb begin
    if (prod_den_q) begin
      term = -ACC_W'(prod_q >>> DEN_SHIFT);
    end else begin
      term = ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_clr) begin
      acc_q <= '0;
    end else if (acc_add) begin
      acc_q <= acc_q + term;
    end
  end

  // floor to Q16.16, saturate, then derive the dac code
  logic signed [ACC_W-1:0] acc_sh;
  logic [ACC_W-Y_W:0]      top;
  logic [X_W-1:0]          code;
  logic                    clip;

  assign acc_sh = acc_q >>> OUT_SHIFT;
  assign top    = acc_sh[ACC_W-1:Y_W-1];

  always_comb begin
    if (&top || ~|top) begin
      y_new = acc_sh[Y_W-1:0];
    end else if (acc_sh[ACC_W-1]) begin
      y_new = {1'b1, {(Y_W-1){1'b0}}};
    end else begin
      y_new = {1'b0, {(Y_W-1){1'b1}}};
    end
  end

  always_comb begin
    if (y_new[Y_W-1]) begin
      // values in (-1, 0) truncate to zero without clipping
      code = '0;
      clip = !((&y_new[Y_W-1:16]) && (|y_new[15:0]));
    end else if (|y_new[Y_W-2:24]) begin
      code = '1;
      clip = 1'b1;
    end else begin
      code = y_new[23:16];
      clip = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wr_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dac_code_o <= code;
      clipped_o  <= clip;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
